[design/hsv2rgb_pkg.sv]
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared types, constants and helper functions of the HSV to RGB converter.
// ----------------------------------------------------------------------------
`default_nettype none

package hsv2rgb_pkg;

    localparam int HUE_W  = 15;
    localparam int LVL_W  = 13;
    localparam int BYTE_W = 8;
    localparam int REST_W = 12;
    localparam int SEC_W  = 3;

    localparam logic [HUE_W-1:0]  HUE_MAX     = 15'd23039;
    localparam logic [LVL_W-1:0]  UNIT_Q12    = 13'd4096;
    localparam logic [REST_W-1:0] SECTOR_SPAN = 12'd3840;

    localparam int QUEUE_DEPTH_DEF = 4;

    typedef logic [1:0] role_t;
    localparam role_t ROLE_CHROMA = 2'd0;
    localparam role_t ROLE_SECOND = 2'd1;
    localparam role_t ROLE_ZERO   = 2'd2;

    typedef struct packed {
        logic [HUE_W-1:0] hue_angle;
        logic [LVL_W-1:0] sat_level;
        logic [LVL_W-1:0] bright_level;
    } hsv_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] red_out;
        logic [BYTE_W-1:0] green_out;
        logic [BYTE_W-1:0] blue_out;
    } rgb_item_t;

    // classified item between front and back
    typedef struct packed {
        logic [LVL_W-1:0]  sat;
        logic [LVL_W-1:0]  val;
        logic [REST_W-1:0] rest;
        role_t             role_r;
        role_t             role_g;
        role_t             role_b;
    } cls_item_t;

    function automatic logic [HUE_W-1:0] sector_base(input logic [SEC_W-1:0] sector);
        logic [HUE_W-1:0] base;
        begin
            case (sector)
                3'd0:    base = 15'd0;
                3'd1:    base = 15'd3840;
                3'd2:    base = 15'd7680;
                3'd3:    base = 15'd11520;
                3'd4:    base = 15'd15360;
                default: base = 15'd19200;
            endcase
            return base;
        end
    endfunction

    // amount of chroma missing from a component
    function automatic logic [REST_W-1:0] weight_of(input role_t role,
                                                    input logic [REST_W-1:0] rest);
        logic [REST_W-1:0] w;
        begin
            case (role)
                ROLE_CHROMA: w = '0;
                ROLE_SECOND: w = rest;
                default:     w = SECTOR_SPAN;
            endcase
            return w;
        end
    endfunction

endpackage

`default_nettype wire

[design/hsv2rgb_front.sv]
// ----------------------------------------------------------------------------
// hsv2rgb_front
// Accepts HSV items, clamps them, finds the hue sector and component roles.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_front (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   hsv_valid,
    output logic                        hsv_ready,
    input  wire hsv2rgb_pkg::hsv_item_t hsv_item,
    output logic                        cls_valid,
    input  wire logic                   cls_ready,
    output hsv2rgb_pkg::cls_item_t      cls_item
);
    import hsv2rgb_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    cls_item_t        item_reg;
    cls_item_t        item_next;
    logic [HUE_W-1:0] hue_c;
    logic [LVL_W-1:0] sat_c;
    logic [LVL_W-1:0] val_c;
    logic [SEC_W-1:0] sector;
    logic [HUE_W-1:0] frac_wide;
    logic [REST_W-1:0] frac;
    logic             load;

    assign hsv_ready = !valid_reg || cls_ready;
    assign load      = hsv_valid && hsv_ready;

    always_comb
    begin
        hue_c = (hsv_item.hue_angle > HUE_MAX) ? HUE_MAX : hsv_item.hue_angle;
        sat_c = (hsv_item.sat_level > UNIT_Q12) ? UNIT_Q12 : hsv_item.sat_level;
        val_c = (hsv_item.bright_level > UNIT_Q12) ? UNIT_Q12 : hsv_item.bright_level;

        if (hue_c >= 15'd19200)
            sector = 3'd5;
        else if (hue_c >= 15'd15360)
            sector = 3'd4;
        else if (hue_c >= 15'd11520)
            sector = 3'd3;
        else if (hue_c >= 15'd7680)
            sector = 3'd2;
        else if (hue_c >= 15'd3840)
            sector = 3'd1;
        else
            sector = 3'd0;

        frac_wide = hue_c - sector_base(sector);
        frac      = frac_wide[REST_W-1:0];

        item_next.sat  = sat_c;
        item_next.val  = val_c;
        item_next.rest = sector[0] ? frac : (SECTOR_SPAN - frac);

        case (sector)
            3'd0:
            begin
                item_next.role_r = ROLE_CHROMA;
                item_next.role_g = ROLE_SECOND;
                item_next.role_b = ROLE_ZERO;
            end
            3'd1:
            begin
                item_next.role_r = ROLE_SECOND;
                item_next.role_g = ROLE_CHROMA;
                item_next.role_b = ROLE_ZERO;
            end
            3'd2:
            begin
                item_next.role_r = ROLE_ZERO;
                item_next.role_g = ROLE_CHROMA;
                item_next.role_b = ROLE_SECOND;
            end
            3'd3:
            begin
                item_next.role_r = ROLE_ZERO;
                item_next.role_g = ROLE_SECOND;
                item_next.role_b = ROLE_CHROMA;
            end
            3'd4:
            begin
                item_next.role_r = ROLE_SECOND;
                item_next.role_g = ROLE_ZERO;
                item_next.role_b = ROLE_CHROMA;
            end
            default:
            begin
                item_next.role_r = ROLE_CHROMA;
                item_next.role_g = ROLE_ZERO;
                item_next.role_b = ROLE_SECOND;
            end
        endcase

        valid_next = hsv_ready ? hsv_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= item_next;
    end

    assign cls_valid = valid_reg;
    assign cls_item  = item_reg;

endmodule

`default_nettype wire

[design/hsv2rgb_queue.sv]
// ----------------------------------------------------------------------------
// hsv2rgb_queue
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_queue #(
    parameter int DEPTH = hsv2rgb_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   enq_valid,
    output logic                        enq_ready,
    input  wire hsv2rgb_pkg::cls_item_t enq_item,
    output logic                        deq_valid,
    input  wire logic                   deq_ready,
    output hsv2rgb_pkg::cls_item_t      deq_item
);
    import hsv2rgb_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cls_item_t        mem [DEPTH];
    logic [IDX_W-1:0] wr_ptr_reg;
    logic [IDX_W-1:0] wr_ptr_next;
    logic [IDX_W-1:0] rd_ptr_reg;
    logic [IDX_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign enq_ready = (count_reg != FULL_CNT);
    assign deq_valid = (count_reg != '0);
    assign deq_item  = mem[rd_ptr_reg];
    assign push      = enq_valid && enq_ready;
    assign pop       = deq_valid && deq_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= enq_item;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count above depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not grow on push");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers differ while empty");

endmodule

`default_nettype wire

[design/hsv2rgb_back.sv]
// ----------------------------------------------------------------------------
// hsv2rgb_back
// Arithmetic pipeline: chroma, weighted products, numerators, rounding.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cls_valid,
    output logic                        cls_ready,
    input  wire hsv2rgb_pkg::cls_item_t cls_item,
    output logic                        rgb_valid,
    input  wire logic                   rgb_ready,
    output hsv2rgb_pkg::rgb_item_t      rgb_item
);
    import hsv2rgb_pkg::*;

    localparam int SV_W  = 25;
    localparam int VK_W  = 24;
    localparam int NUM_W = 36;
    localparam int ACC_W = 40;
    localparam logic [ACC_W-1:0] HALF_LSB = 40'h0080000000;

    // stage 1
    logic              v1_reg;
    logic              v1_next;
    logic [SV_W-1:0]   sv1_reg;
    logic [LVL_W-1:0]  val1_reg;
    logic [REST_W-1:0] rest1_reg;
    role_t             rr1_reg;
    role_t             rg1_reg;
    role_t             rb1_reg;
    // stage 2
    logic              v2_reg;
    logic              v2_next;
    logic [VK_W-1:0]   vk2_reg;
    logic [NUM_W-1:0]  pr2_reg;
    logic [NUM_W-1:0]  pg2_reg;
    logic [NUM_W-1:0]  pb2_reg;
    // stage 3
    logic              v3_reg;
    logic              v3_next;
    logic [NUM_W-1:0]  nr3_reg;
    logic [NUM_W-1:0]  ng3_reg;
    logic [NUM_W-1:0]  nb3_reg;
    // output
    logic              vo_reg;
    logic              vo_next;
    rgb_item_t         out_reg;
    rgb_item_t         out_next;

    logic              en1;
    logic              en2;
    logic              en3;
    logic              eno;
    logic [NUM_W-1:0]  top_num;
    logic [ACC_W-1:0]  acc_r;
    logic [ACC_W-1:0]  acc_g;
    logic [ACC_W-1:0]  acc_b;

    assign eno       = !vo_reg || rgb_ready;
    assign en3       = !v3_reg || eno;
    assign en2       = !v2_reg || en3;
    assign en1       = !v1_reg || en2;
    assign cls_ready = en1;

    assign v1_next = en1 ? cls_valid : v1_reg;
    assign v2_next = en2 ? v1_reg : v2_reg;
    assign v3_next = en3 ? v2_reg : v3_reg;
    assign vo_next = eno ? v3_reg : vo_reg;

    assign top_num = {vk2_reg, 12'b0};

    always_comb
    begin
        acc_r = {nr3_reg, 4'b0} + ACC_W'(nr3_reg) + HALF_LSB;
        acc_g = {ng3_reg, 4'b0} + ACC_W'(ng3_reg) + HALF_LSB;
        acc_b = {nb3_reg, 4'b0} + ACC_W'(nb3_reg) + HALF_LSB;
        out_next.red_out   = acc_r[ACC_W-1:ACC_W-BYTE_W];
        out_next.green_out = acc_g[ACC_W-1:ACC_W-BYTE_W];
        out_next.blue_out  = acc_b[ACC_W-1:ACC_W-BYTE_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            vo_reg <= vo_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            sv1_reg   <= SV_W'(cls_item.sat) * SV_W'(cls_item.val);
            val1_reg  <= cls_item.val;
            rest1_reg <= cls_item.rest;
            rr1_reg   <= cls_item.role_r;
            rg1_reg   <= cls_item.role_g;
            rb1_reg   <= cls_item.role_b;
        end
        if (en2)
        begin
            vk2_reg <= VK_W'(val1_reg) * VK_W'(SECTOR_SPAN);
            pr2_reg <= NUM_W'(sv1_reg) * NUM_W'(weight_of(rr1_reg, rest1_reg));
            pg2_reg <= NUM_W'(sv1_reg) * NUM_W'(weight_of(rg1_reg, rest1_reg));
            pb2_reg <= NUM_W'(sv1_reg) * NUM_W'(weight_of(rb1_reg, rest1_reg));
        end
        if (en3)
        begin
            nr3_reg <= top_num - pr2_reg;
            ng3_reg <= top_num - pg2_reg;
            nb3_reg <= top_num - pb2_reg;
        end
        if (eno)
            out_reg <= out_next;
    end

    assign rgb_valid = vo_reg;
    assign rgb_item  = out_reg;

    a_full_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !cls_ready |-> v1_reg && v2_reg && v3_reg && vo_reg)
        else $error("back stalled with a free stage");

    a_stage3_holds: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && vo_reg && !rgb_ready |=> v3_reg && $stable(nr3_reg))
        else $error("stage 3 lost an item during a stall");

    a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
        cls_valid && cls_ready |=> v1_reg)
        else $error("taken item missing from stage 1");

endmodule

`default_nettype wire

[design/hsv_to_rgb_converter.sv]
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Converts one HSV item (hue in 1/64 degree, Q1.12 saturation and value)
// to one 8-bit RGB item, rounded half up.
//
//   channel | signals                          | direction | payload
//   hsv     | hsv_valid, hsv_ready, hsv_item   | in        | hsv_item_t
//   rgb     | rgb_valid, rgb_ready, rgb_item   | out       | rgb_item_t
//
// one item per cycle sustained while rgb_ready stays high
// stages: front register, queue, chroma multiply, weight multiply,
// numerator subtract, rounding register
// reset clears only valid flags, the queue count and the queue pointers
// the queue lets the front keep taking items, up to its depth, while the back is stalled
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_converter #(
    parameter int QUEUE_DEPTH = hsv2rgb_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   hsv_valid,
    output logic                        hsv_ready,
    input  wire hsv2rgb_pkg::hsv_item_t hsv_item,
    output logic                        rgb_valid,
    input  wire logic                   rgb_ready,
    output hsv2rgb_pkg::rgb_item_t      rgb_item
);
    import hsv2rgb_pkg::*;

    logic      f_valid;
    logic      f_ready;
    cls_item_t f_item;
    logic      q_valid;
    logic      q_ready;
    cls_item_t q_item;

    hsv2rgb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .hsv_valid (hsv_valid),
        .hsv_ready (hsv_ready),
        .hsv_item  (hsv_item),
        .cls_valid (f_valid),
        .cls_ready (f_ready),
        .cls_item  (f_item)
    );

    hsv2rgb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .enq_valid (f_valid),
        .enq_ready (f_ready),
        .enq_item  (f_item),
        .deq_valid (q_valid),
        .deq_ready (q_ready),
        .deq_item  (q_item)
    );

    hsv2rgb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cls_valid (q_valid),
        .cls_ready (q_ready),
        .cls_item  (q_item),
        .rgb_valid (rgb_valid),
        .rgb_ready (rgb_ready),
        .rgb_item  (rgb_item)
    );

endmodule

`default_nettype wire

[test/tb_hsv_to_rgb_converter.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hsv_to_rgb_converter
// Self-checking bench for the HSV to RGB converter. A short table of colors
// (primaries, secondaries, greys, clamped fields) is followed by random items
// biased toward sector edges and out-of-range fields. Each result is checked
// against the table's known color or an exact integer model of the conversion,
// under random gaps on the hsv side and random stalls on the rgb side.
// ----------------------------------------------------------------------------

module tb_hsv_to_rgb_converter;

    import hsv2rgb_pkg::*;

    localparam int RANDOM_ITEMS = 1750;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 12;

    typedef struct {
        hsv_item_t hsv;
        bit        known;
        rgb_item_t rgb;
    } color_row_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      hsv_valid = 1'b0;
    logic      hsv_ready;
    hsv_item_t hsv_item  = '0;
    logic      rgb_valid;
    logic      rgb_ready = 1'b0;
    rgb_item_t rgb_item;

    rgb_item_t  pending_rgb[$];
    color_row_t color_rows[$];
    bit         calm;
    int         mismatch_count;
    int         cycle_count;
    int         sent_count;
    int         checked_count;
    int         clamped_count;

    hsv_to_rgb_converter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .hsv_valid (hsv_valid),
        .hsv_ready (hsv_ready),
        .hsv_item  (hsv_item),
        .rgb_valid (rgb_valid),
        .rgb_ready (rgb_ready),
        .rgb_item  (rgb_item)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, pending_rgb.size());
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [BYTE_W-1:0] round_to_byte(input logic [63:0] num);
        logic [63:0] den;
        logic [63:0] q;
        begin
            den = 64'(SECTOR_SPAN) << 24;
            q   = (num * 64'd255 + den / 64'd2) / den;
            return (q > 64'd255) ? 8'd255 : q[BYTE_W-1:0];
        end
    endfunction

    function automatic rgb_item_t rgb_of_hsv(input hsv_item_t px);
        logic [63:0] h, s, v, span, sector, f, t, sv, cn, xn, mn, r, g, b;
        rgb_item_t   res;
        begin
            span = 64'(SECTOR_SPAN);
            h = (px.hue_angle > HUE_MAX) ? 64'(HUE_MAX) : 64'(px.hue_angle);
            s = (px.sat_level > UNIT_Q12) ? 64'(UNIT_Q12) : 64'(px.sat_level);
            v = (px.bright_level > UNIT_Q12) ? 64'(UNIT_Q12) : 64'(px.bright_level);
            sector = h / span;
            f  = h % span;
            t  = sector[0] ? (span - f) : f;
            sv = s * v;
            cn = sv * span;
            xn = sv * t;
            mn = (v * 64'(UNIT_Q12) - sv) * span;
            case (sector)
                64'd0:   begin r = cn; g = xn; b = 0;  end
                64'd1:   begin r = xn; g = cn; b = 0;  end
                64'd2:   begin r = 0;  g = cn; b = xn; end
                64'd3:   begin r = 0;  g = xn; b = cn; end
                64'd4:   begin r = xn; g = 0;  b = cn; end
                default: begin r = cn; g = 0;  b = xn; end
            endcase
            res.red_out   = round_to_byte(r + mn);
            res.green_out = round_to_byte(g + mn);
            res.blue_out  = round_to_byte(b + mn);
            return res;
        end
    endfunction

    function automatic int pick_pause();
        int roll;
        begin
            roll = $urandom_range(0, 99);
            if (calm || roll < 60)
                return 0;
            else if (roll < 92)
                return $urandom_range(1, 3);
            else
                return $urandom_range(5, 30);
        end
    endfunction

    function automatic logic [LVL_W-1:0] random_level();
        int roll;
        begin
            roll = $urandom_range(0, 99);
            if (roll < 70)
                return LVL_W'($urandom_range(0, 4096));
            else if (roll < 80)
                return ($urandom_range(0, 1) != 0) ? UNIT_Q12 : '0;
            else
                return LVL_W'($urandom());
        end
    endfunction

    function automatic hsv_item_t random_hsv();
        hsv_item_t px;
        int        roll;
        begin
            roll = $urandom_range(0, 99);
            if (roll < 80)
                px.hue_angle = HUE_W'($urandom_range(0, 23039));
            else if (roll < 90)
                px.hue_angle = HUE_W'($urandom_range(0, 6) * 3840 + $urandom_range(0, 2) - 1);
            else
                px.hue_angle = HUE_W'($urandom());
            px.sat_level    = random_level();
            px.bright_level = random_level();
            return px;
        end
    endfunction

    task automatic send_hsv(input hsv_item_t px, input bit known, input rgb_item_t rgb);
        int pause;
        begin
            pause = pick_pause();
            if (pause > 0)
            begin
                hsv_valid <= 1'b0;
                repeat (pause) @(posedge clk);
            end
            hsv_valid <= 1'b1;
            hsv_item  <= px;
            do @(posedge clk); while (!(hsv_valid && hsv_ready));
            pending_rgb.push_back(known ? rgb : rgb_of_hsv(px));
            sent_count++;
            if (px.hue_angle > HUE_MAX || px.sat_level > UNIT_Q12 || px.bright_level > UNIT_Q12)
                clamped_count++;
        end
    endtask

    task automatic wait_for_results();
        begin
            hsv_valid <= 1'b0;
            while (pending_rgb.size() != 0)
                @(posedge clk);
        end
    endtask

    // rgb side: random stalls and result checking
    initial
    begin
        rgb_item_t want;
        int        stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rgb_valid && rgb_ready)
            begin
                if (pending_rgb.size() == 0)
                begin
                    $display("%0t: unexpected item r=%0d g=%0d b=%0d", $time,
                             rgb_item.red_out, rgb_item.green_out, rgb_item.blue_out);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_rgb.pop_front();
                    checked_count++;
                    if (rgb_item.red_out !== want.red_out)
                    begin
                        $display("%0t: red expected %0d actual %0d", $time,
                                 want.red_out, rgb_item.red_out);
                        mismatch_count++;
                    end
                    if (rgb_item.green_out !== want.green_out)
                    begin
                        $display("%0t: green expected %0d actual %0d", $time,
                                 want.green_out, rgb_item.green_out);
                        mismatch_count++;
                    end
                    if (rgb_item.blue_out !== want.blue_out)
                    begin
                        $display("%0t: blue expected %0d actual %0d", $time,
                                 want.blue_out, rgb_item.blue_out);
                        mismatch_count++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rgb_ready <= 1'b0;
            end
            else
            begin
                stall_left = pick_pause();
                rgb_ready <= (stall_left == 0);
            end
        end
    end

    initial
    begin
        hsv_item_t px;
        color_row_t row;
        calm           = 1'b0;
        mismatch_count = 0;
        sent_count     = 0;
        checked_count  = 0;
        clamped_count  = 0;

        // hue, saturation, value, known, red, green, blue
        color_rows.push_back('{'{15'd0,     13'd0,    13'd0},    1'b1, '{8'd0,   8'd0,   8'd0}});
        color_rows.push_back('{'{15'd0,     13'd0,    13'd4096}, 1'b1, '{8'd255, 8'd255, 8'd255}});
        color_rows.push_back('{'{15'd0,     13'd4096, 13'd4096}, 1'b1, '{8'd255, 8'd0,   8'd0}});
        color_rows.push_back('{'{15'd3840,  13'd4096, 13'd4096}, 1'b1, '{8'd255, 8'd255, 8'd0}});
        color_rows.push_back('{'{15'd7680,  13'd4096, 13'd4096}, 1'b1, '{8'd0,   8'd255, 8'd0}});
        color_rows.push_back('{'{15'd11520, 13'd4096, 13'd4096}, 1'b1, '{8'd0,   8'd255, 8'd255}});
        color_rows.push_back('{'{15'd15360, 13'd4096, 13'd4096}, 1'b1, '{8'd0,   8'd0,   8'd255}});
        color_rows.push_back('{'{15'd19200, 13'd4096, 13'd4096}, 1'b1, '{8'd255, 8'd0,   8'd255}});
        color_rows.push_back('{'{15'd23039, 13'd4096, 13'd4096}, 1'b1, '{8'd255, 8'd0,   8'd0}});
        color_rows.push_back('{'{15'd32767, 13'd4096, 13'd4096}, 1'b1, '{8'd255, 8'd0,   8'd0}});
        color_rows.push_back('{'{15'd0,     13'd8191, 13'd8191}, 1'b1, '{8'd255, 8'd0,   8'd0}});
        color_rows.push_back('{'{15'd0,     13'd0,    13'd2048}, 1'b1, '{8'd128, 8'd128, 8'd128}});
        color_rows.push_back('{'{15'd0,     13'd0,    13'd8191}, 1'b1, '{8'd255, 8'd255, 8'd255}});
        color_rows.push_back('{'{15'd1920,  13'd4096, 13'd4096}, 1'b1, '{8'd255, 8'd128, 8'd0}});
        color_rows.push_back('{'{15'd23039, 13'd0,    13'd4096}, 1'b1, '{8'd255, 8'd255, 8'd255}});
        color_rows.push_back('{'{15'd12345, 13'd4096, 13'd0},    1'b1, '{8'd0,   8'd0,   8'd0}});
        color_rows.push_back('{'{15'd5000,  13'd2048, 13'd4096}, 1'b0, '0});
        color_rows.push_back('{'{15'd3839,  13'd4096, 13'd4096}, 1'b0, '0});
        color_rows.push_back('{'{15'd20000, 13'd1234, 13'd3000}, 1'b0, '0});
        color_rows.push_back('{'{15'd16383, 13'd8191, 13'd2047}, 1'b0, '0});
        color_rows.push_back('{'{15'd11519, 13'd1,    13'd1},    1'b0, '0});
        color_rows.push_back('{'{15'd7679,  13'd4095, 13'd4095}, 1'b0, '0});
        color_rows.push_back('{'{15'd24000, 13'd5000, 13'd6000}, 1'b0, '0});

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (color_rows[i])
        begin
            row = color_rows[i];
            send_hsv(row.hsv, row.known, row.rgb);
        end

        // hold the input until the pipeline has drained
        wait_for_results();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 250 == 0)
                calm = ($urandom_range(0, 2) == 0);
            if (n % 600 == 599)
                wait_for_results();
            px = random_hsv();
            send_hsv(px, 1'b0, '0);
        end
        hsv_valid <= 1'b0;

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("converted %0d items (%0d with clamped fields), %0d results checked",
                 sent_count, clamped_count, checked_count);
        $display("covered all six hue sectors, grey levels and random gaps and stalls");
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[hsv_to_rgb_converter.f]
design/hsv2rgb_pkg.sv
design/hsv2rgb_front.sv
design/hsv2rgb_queue.sv
design/hsv2rgb_back.sv
design/hsv_to_rgb_converter.sv
test/tb_hsv_to_rgb_converter.sv
